/* rtl/core/rpj_pkg.sv */
// Shared types and constants for the disparity-to-point reprojection core.
// Holds the transaction structs, register indexes and reset values.
// No dependencies.
`default_nettype none

package rpj_pkg;

	localparam int DEF_COORD_BITS = 12;
	localparam int DEF_FRAC_BITS  = 8;

	localparam int PIX_W   = 12;
	localparam int CODE_W  = 8;
	localparam int MAXD_W  = 10;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int OUT_W   = 32;
	localparam int ZQ_W    = 2 * CFG_W;
	localparam int PROD_W  = CODE_W + MAXD_W;

	// Clock edges from the edge that accepts a transaction to the edge that
	// accepts its result strobe.
	localparam int PIPE_LAT = 86;

	localparam logic [CODE_W-1:0] INVALID_CODE = 8'd255;

	localparam logic [IDX_W-1:0] REG_MAX_DISP    = 3'd0;
	localparam logic [IDX_W-1:0] REG_BASELINE    = 3'd1;
	localparam logic [IDX_W-1:0] REG_FOCAL       = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_ROW  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CENTER_COL  = 3'd4;
	localparam logic [IDX_W-1:0] REG_DISP_OFFSET = 3'd5;

	localparam logic [MAXD_W-1:0] RST_MAX_DISP = 10'd255;
	localparam logic [CFG_W-1:0]  RST_BASELINE = 24'd256;
	localparam logic [CFG_W-1:0]  RST_FOCAL    = 24'd256;

	typedef struct packed {
		logic [PIX_W-1:0]  pix_row;
		logic [PIX_W-1:0]  pix_col;
		logic [CODE_W-1:0] disp_code;
	} pixel_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] point_x;
		logic signed [OUT_W-1:0] point_y;
		logic [OUT_W-1:0]        point_z;
	} point_t;

	typedef struct packed {
		logic [MAXD_W-1:0] max_disparity;
		logic [CFG_W-1:0]  baseline_len;
		logic [CFG_W-1:0]  focal_px;
		logic [CFG_W-1:0]  center_row;
		logic [CFG_W-1:0]  center_col;
		logic [CFG_W-1:0]  disp_offset;
	} cfg_regs_t;

endpackage

`default_nettype wire

/* rtl/core/rpj_div_cell.sv */
// One restoring-division cell: develops one quotient bit per transaction.
// Cells are chained; each passes remainder, dividend, quotient and sideband on.
// Depends on nothing.
`default_nettype none

module rpj_div_cell #(
	parameter int DEN_W  = 24,
	parameter int NUM_W  = 32,
	parameter int SIDE_W = 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [DEN_W-1:0]  in_rem,
	input  wire logic [NUM_W-1:0]  in_num,
	input  wire logic [NUM_W-1:0]  in_quo,
	input  wire logic [DEN_W-1:0]  in_den,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_valid,
	output logic [DEN_W-1:0]       out_rem,
	output logic [NUM_W-1:0]       out_num,
	output logic [NUM_W-1:0]       out_quo,
	output logic [DEN_W-1:0]       out_den,
	output logic [SIDE_W-1:0]      out_side
);

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {in_rem, in_num[NUM_W-1]};
		diff  = trial - {1'b0, in_den};
		ge    = (trial >= {1'b0, in_den});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	// The remainder stays below the divisor, so it fits DEN_W bits.
	always_ff @(posedge clk) begin
		out_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		out_num  <= {in_num[NUM_W-2:0], 1'b0};
		out_quo  <= {in_quo[NUM_W-2:0], ge};
		out_den  <= in_den;
		out_side <= in_side;
	end

endmodule

`default_nettype wire

/* rtl/core/rpj_cfg_regs.sv */
// Configuration register file of the reprojection core, plus the registered
// baseline * focal product. Depends on rpj_pkg.
`default_nettype none

module rpj_cfg_regs (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire logic [rpj_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [rpj_pkg::CFG_W-1:0]   cfg_data,
	output rpj_pkg::cfg_regs_t               regs,
	output logic [rpj_pkg::ZQ_W-1:0]         depth_num
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.max_disparity <= rpj_pkg::RST_MAX_DISP;
			regs.baseline_len  <= rpj_pkg::RST_BASELINE;
			regs.focal_px      <= rpj_pkg::RST_FOCAL;
			regs.center_row    <= '0;
			regs.center_col    <= '0;
			regs.disp_offset   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				rpj_pkg::REG_MAX_DISP: begin
					regs.max_disparity <= cfg_data[rpj_pkg::MAXD_W-1:0];
				end
				rpj_pkg::REG_BASELINE:    regs.baseline_len <= cfg_data;
				rpj_pkg::REG_FOCAL:       regs.focal_px     <= cfg_data;
				rpj_pkg::REG_CENTER_ROW:  regs.center_row   <= cfg_data;
				rpj_pkg::REG_CENTER_COL:  regs.center_col   <= cfg_data;
				rpj_pkg::REG_DISP_OFFSET: regs.disp_offset  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Change settings only while idle (unchecked); product settles first.
	always_ff @(posedge clk) begin
		depth_num <= rpj_pkg::ZQ_W'(regs.baseline_len) * rpj_pkg::ZQ_W'(regs.focal_px);
	end

endmodule

`default_nettype wire

/* rtl/core/disparity_to_point_reprojection_core.sv */
// Disparity-to-point reprojection core: turns one pixel and disparity code per
// cycle into X, Y, Z. Depends on rpj_pkg, rpj_cfg_regs and rpj_div_cell.
//
// The core is fully pipelined: it takes one pixel every clock (busy never rises)
// and raises the one-cycle done strobe for each pixel that yields a result. The
// pipeline consists of three front stages, two chains of division cells, 48 cells
// for the depth quotient and 32 cells for the X and Y quotients, one bit per cell,
// two product stages and the output register. The receiver cannot stall the core,
// so results must be captured when done is high.
// Pixels with code 255, a zero denominator or a zero depth give no strobe.
// Settings may be written only while no pixel is in flight.
`default_nettype none

module disparity_to_point_reprojection_core #(
	parameter int COORD_BITS = rpj_pkg::DEF_COORD_BITS,
	parameter int FRAC_BITS  = rpj_pkg::DEF_FRAC_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	output logic                           busy,
	input  wire rpj_pkg::pixel_t           pixel,
	output logic                           done,
	output rpj_pkg::point_t                result,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [rpj_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [rpj_pkg::CFG_W-1:0] cfg_data
);

	localparam int CW     = (COORD_BITS < rpj_pkg::PIX_W) ? COORD_BITS : rpj_pkg::PIX_W;
	localparam int CQ_W   = CW + FRAC_BITS;
	localparam int MAG_W  = (CQ_W > rpj_pkg::CFG_W) ? CQ_W : rpj_pkg::CFG_W;
	localparam int DSH_W  = rpj_pkg::MAXD_W + FRAC_BITS;
	localparam int DEN_W  = ((DSH_W > rpj_pkg::CFG_W) ? DSH_W : rpj_pkg::CFG_W) + 1;
	localparam int ZQ_W   = rpj_pkg::ZQ_W;
	localparam int HALF_W = rpj_pkg::CFG_W;
	localparam int MP_W   = MAG_W + HALF_W;
	localparam int PW     = MAG_W + ZQ_W;
	localparam int Q_W    = rpj_pkg::OUT_W;
	localparam int HI_W   = PW - Q_W;
	localparam int SIDE1_W = 2 * MAG_W + 2;
	localparam int SIDEX_W = Q_W + 2;
	localparam int SIDEY_W = 2;
	localparam int PROD_W = rpj_pkg::PROD_W;
	localparam int EST_W  = PROD_W + 9;

	rpj_pkg::cfg_regs_t cfg;
	logic [ZQ_W-1:0]    depth_num;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	rpj_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (cfg),
		.depth_num (depth_num)
	);

	// Stage 1: scale product and signed offsets from the principal point.
	logic [MAG_W-1:0] cq_row, cq_col, cr_ext, cc_ext;
	logic             negx_c, negy_c;

	always_comb begin
		cq_row = MAG_W'(pixel.pix_row[CW-1:0]) << FRAC_BITS;
		cq_col = MAG_W'(pixel.pix_col[CW-1:0]) << FRAC_BITS;
		cr_ext = MAG_W'(cfg.center_row);
		cc_ext = MAG_W'(cfg.center_col);
		negx_c = cq_row < cr_ext;
		negy_c = cq_col < cc_ext;
	end

	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [MAG_W-1:0]  magx_s1, magy_s1;
	logic              negx_s1, negy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy && (pixel.disp_code != rpj_pkg::INVALID_CODE);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(pixel.disp_code) * PROD_W'(cfg.max_disparity);
		magx_s1 <= negx_c ? (cr_ext - cq_row) : (cq_row - cr_ext);
		magy_s1 <= negy_c ? (cc_ext - cq_col) : (cq_col - cc_ext);
		negx_s1 <= negx_c;
		negy_s1 <= negy_c;
	end

	// Stage 2: divide by 255 as a multiply by 257/65536 and one correction step.
	logic [EST_W-1:0]  est_sum;
	logic [10:0]       q_est;
	logic [PROD_W:0]   q_rem;
	logic [10:0]       q_fix;

	always_comb begin
		est_sum = EST_W'(prod_s1) + (EST_W'(prod_s1) << 8);
		q_est   = est_sum[26:16];
		q_rem   = (PROD_W + 1)'(prod_s1) - (((PROD_W + 1)'(q_est) << 8) - (PROD_W + 1)'(q_est));
		q_fix   = (q_rem >= (PROD_W + 1)'(255)) ? (q_est + 11'd1) : q_est;
	end

	logic                      valid_s2;
	logic [rpj_pkg::MAXD_W-1:0] disp_s2;
	logic [SIDE1_W-1:0]        side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		disp_s2 <= q_fix[rpj_pkg::MAXD_W-1:0];
		side_s2 <= {negx_s1, magx_s1, negy_s1, magy_s1};
	end

	// Stage 3: denominator in fixed point.
	logic [DEN_W-1:0] den_c;
	assign den_c = (DEN_W'(disp_s2) << FRAC_BITS) + DEN_W'(cfg.disp_offset);

	logic               valid_s3;
	logic [DEN_W-1:0]   den_s3;
	logic [SIDE1_W-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2 && (den_c != '0);
		end
	end

	always_ff @(posedge clk) begin
		den_s3  <= den_c;
		side_s3 <= side_s2;
	end

	// Depth chain: Zq = baseline * focal / den, one bit per cell.
	logic               c1_valid [0:ZQ_W];
	logic [DEN_W-1:0]   c1_rem   [0:ZQ_W];
	logic [ZQ_W-1:0]    c1_num   [0:ZQ_W];
	logic [ZQ_W-1:0]    c1_quo   [0:ZQ_W];
	logic [DEN_W-1:0]   c1_den   [0:ZQ_W];
	logic [SIDE1_W-1:0] c1_side  [0:ZQ_W];

	assign c1_valid[0] = valid_s3;
	assign c1_rem[0]   = '0;
	assign c1_num[0]   = depth_num;
	assign c1_quo[0]   = '0;
	assign c1_den[0]   = den_s3;
	assign c1_side[0]  = side_s3;

	for (genvar i = 0; i < ZQ_W; i++) begin : g_depth
		rpj_div_cell #(
			.DEN_W  (DEN_W),
			.NUM_W  (ZQ_W),
			.SIDE_W (SIDE1_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (c1_valid[i]),
			.in_rem    (c1_rem[i]),
			.in_num    (c1_num[i]),
			.in_quo    (c1_quo[i]),
			.in_den    (c1_den[i]),
			.in_side   (c1_side[i]),
			.out_valid (c1_valid[i+1]),
			.out_rem   (c1_rem[i+1]),
			.out_num   (c1_num[i+1]),
			.out_quo   (c1_quo[i+1]),
			.out_den   (c1_den[i+1]),
			.out_side  (c1_side[i+1])
		);
	end

	// Stage 4: partial products of the offsets with Zq.
	logic [ZQ_W-1:0]  zq;
	logic             negx_c1, negy_c1;
	logic [MAG_W-1:0] magx_c1, magy_c1;

	assign zq = c1_quo[ZQ_W];
	assign {negx_c1, magx_c1, negy_c1, magy_c1} = c1_side[ZQ_W];

	logic             valid_s4;
	logic [MP_W-1:0]  xlo_s4, xhi_s4, ylo_s4, yhi_s4;
	logic [Q_W-1:0]   z_s4;
	logic             negx_s4, negy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= c1_valid[ZQ_W] && (zq != '0);
		end
	end

	always_ff @(posedge clk) begin
		xlo_s4  <= MP_W'(magx_c1) * MP_W'(zq[HALF_W-1:0]);
		xhi_s4  <= MP_W'(magx_c1) * MP_W'(zq[ZQ_W-1:HALF_W]);
		ylo_s4  <= MP_W'(magy_c1) * MP_W'(zq[HALF_W-1:0]);
		yhi_s4  <= MP_W'(magy_c1) * MP_W'(zq[ZQ_W-1:HALF_W]);
		z_s4    <= (zq[ZQ_W-1:Q_W] != '0) ? '1 : zq[Q_W-1:0];
		negx_s4 <= negx_c1;
		negy_s4 <= negy_c1;
	end

	// Stage 5: full products; a high part at or above focal means the quotient
	// reaches 2^32 and saturates, otherwise it seeds the remainder.
	logic [PW-1:0] px_c, py_c;
	logic          satx_c, saty_c;

	always_comb begin
		px_c   = PW'(xlo_s4) + (PW'(xhi_s4) << HALF_W);
		py_c   = PW'(ylo_s4) + (PW'(yhi_s4) << HALF_W);
		satx_c = px_c[PW-1:Q_W] >= HI_W'(cfg.focal_px);
		saty_c = py_c[PW-1:Q_W] >= HI_W'(cfg.focal_px);
	end

	logic                      valid_s5;
	logic [rpj_pkg::CFG_W-1:0] remx_s5, remy_s5;
	logic [Q_W-1:0]            numx_s5, numy_s5;
	logic [SIDEX_W-1:0]        sidex_s5;
	logic [SIDEY_W-1:0]        sidey_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		remx_s5  <= satx_c ? '0 : px_c[Q_W +: rpj_pkg::CFG_W];
		remy_s5  <= saty_c ? '0 : py_c[Q_W +: rpj_pkg::CFG_W];
		numx_s5  <= px_c[Q_W-1:0];
		numy_s5  <= py_c[Q_W-1:0];
		sidex_s5 <= {negx_s4, satx_c, z_s4};
		sidey_s5 <= {negy_s4, saty_c};
	end

	// Projection chains: |offset| * Zq / focal for X and Y side by side.
	logic                      cx_valid [0:Q_W];
	logic [rpj_pkg::CFG_W-1:0] cx_rem   [0:Q_W];
	logic [Q_W-1:0]            cx_num   [0:Q_W];
	logic [Q_W-1:0]            cx_quo   [0:Q_W];
	logic [rpj_pkg::CFG_W-1:0] cx_den   [0:Q_W];
	logic [SIDEX_W-1:0]        cx_side  [0:Q_W];
	logic                      cy_valid [0:Q_W];
	logic [rpj_pkg::CFG_W-1:0] cy_rem   [0:Q_W];
	logic [Q_W-1:0]            cy_num   [0:Q_W];
	logic [Q_W-1:0]            cy_quo   [0:Q_W];
	logic [rpj_pkg::CFG_W-1:0] cy_den   [0:Q_W];
	logic [SIDEY_W-1:0]        cy_side  [0:Q_W];

	assign cx_valid[0] = valid_s5;
	assign cx_rem[0]   = remx_s5;
	assign cx_num[0]   = numx_s5;
	assign cx_quo[0]   = '0;
	assign cx_den[0]   = cfg.focal_px;
	assign cx_side[0]  = sidex_s5;
	assign cy_valid[0] = valid_s5;
	assign cy_rem[0]   = remy_s5;
	assign cy_num[0]   = numy_s5;
	assign cy_quo[0]   = '0;
	assign cy_den[0]   = cfg.focal_px;
	assign cy_side[0]  = sidey_s5;

	for (genvar i = 0; i < Q_W; i++) begin : g_proj
		rpj_div_cell #(
			.DEN_W  (rpj_pkg::CFG_W),
			.NUM_W  (Q_W),
			.SIDE_W (SIDEX_W)
		) u_cell_x (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cx_valid[i]),
			.in_rem    (cx_rem[i]),
			.in_num    (cx_num[i]),
			.in_quo    (cx_quo[i]),
			.in_den    (cx_den[i]),
			.in_side   (cx_side[i]),
			.out_valid (cx_valid[i+1]),
			.out_rem   (cx_rem[i+1]),
			.out_num   (cx_num[i+1]),
			.out_quo   (cx_quo[i+1]),
			.out_den   (cx_den[i+1]),
			.out_side  (cx_side[i+1])
		);

		rpj_div_cell #(
			.DEN_W  (rpj_pkg::CFG_W),
			.NUM_W  (Q_W),
			.SIDE_W (SIDEY_W)
		) u_cell_y (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (cy_valid[i]),
			.in_rem    (cy_rem[i]),
			.in_num    (cy_num[i]),
			.in_quo    (cy_quo[i]),
			.in_den    (cy_den[i]),
			.in_side   (cy_side[i]),
			.out_valid (cy_valid[i+1]),
			.out_rem   (cy_rem[i+1]),
			.out_num   (cy_num[i+1]),
			.out_quo   (cy_quo[i+1]),
			.out_den   (cy_den[i+1]),
			.out_side  (cy_side[i+1])
		);
	end

	// Negative results may reach -2^31, positive ones stop at 2^31 - 1.
	function automatic logic [Q_W-1:0] clamp_signed(
		input logic [Q_W-1:0] q,
		input logic           sat,
		input logic           neg
	);
		logic           cap;
		logic [Q_W-1:0] lim;
		logic [Q_W-1:0] mag;
		lim = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		cap = sat || (q > lim);
		mag = cap ? lim : q;
		return neg ? (~mag + 1'b1) : mag;
	endfunction

	logic           negx_f, satx_f, negy_f, saty_f;
	logic [Q_W-1:0] z_f;

	assign {negx_f, satx_f, z_f} = cx_side[Q_W];
	assign {negy_f, saty_f}      = cy_side[Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cx_valid[Q_W] && cy_valid[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		result.point_x <= clamp_signed(cx_quo[Q_W], satx_f, negx_f);
		result.point_y <= clamp_signed(cy_quo[Q_W], saty_f, negy_f);
		result.point_z <= z_f;
	end

endmodule

`default_nettype wire

/* rtl/core/rpj_checker.sv */
// Port-level checks for the reprojection core, attached with bind.
// Depends on rpj_pkg and disparity_to_point_reprojection_core.
`default_nettype none

module rpj_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      start,
	input wire logic                      busy,
	input wire rpj_pkg::pixel_t           pixel,
	input wire logic                      done,
	input wire rpj_pkg::point_t           result
);

	// A result strobe always traces back to a transaction a fixed time earlier.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, rpj_pkg::PIPE_LAT))
		else $error("result strobe without a matching input transaction");

	// An invalid disparity code never produces a result.
	a_invalid_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (pixel.disp_code == rpj_pkg::INVALID_CODE))
			|-> ##(rpj_pkg::PIPE_LAT) !done)
		else $error("invalid pixel produced a result");

	// Depth of a delivered point is never zero.
	a_depth_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.point_z != '0))
		else $error("result with zero depth");

endmodule

bind disparity_to_point_reprojection_core rpj_checker u_rpj_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.pixel  (pixel),
	.done   (done),
	.result (result)
);

`default_nettype wire
